[rtl/gray_level_binned_histogram_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the gray-level histogram checker
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRAY_LEVEL_BINNED_HISTOGRAM_TOP_ASSERT_SVH
`define GRAY_LEVEL_BINNED_HISTOGRAM_TOP_ASSERT_SVH

// Same-cycle implication.
`define GLBH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("histogram check failed");

// Next-cycle implication.
`define GLBH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("histogram check failed");

`endif

[rtl/glbh_pkg.sv]
// ----------------------------------------------------------------------------
// glbh_pkg
// Shared constants, types and helper functions of the gray-level histogram.
// ----------------------------------------------------------------------------
package glbh_pkg;

    localparam int PIX_W       = 8;
    localparam int BIN_W       = 5;
    localparam int NUM_BINS    = 26;
    localparam int BIN_SPAN    = 10;
    localparam int SPAN_TOP    = 9;
    localparam int GRAY_MAX    = 255;
    localparam int COUNT_WIDTH = 16;
    localparam int OUT_CNT_W   = 16;

    // pixel / 10 as (pixel * 205) >> 11, exact over the 8-bit range
    localparam int RECIP     = 205;
    localparam int RECIP_SH  = 11;
    localparam int PROD_W    = PIX_W + 8;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

    typedef logic [BIN_W-1:0]       bin_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef struct packed {
        bin_t bin;
        logic frame_end;
    } entry_t;

    function automatic bin_t pixel_to_bin(input logic [PIX_W-1:0] pix);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(pix) * PROD_W'(RECIP);
        return bin_t'(prod >> RECIP_SH);
    endfunction

    function automatic logic [PIX_W-1:0] bin_start(input bin_t idx);
        return PIX_W'(idx) * PIX_W'(BIN_SPAN);
    endfunction

    function automatic logic [PIX_W-1:0] bin_end(input bin_t idx);
        logic [PIX_W:0] hi;
        hi = (PIX_W + 1)'(bin_start(idx)) + (PIX_W + 1)'(SPAN_TOP);
        return (hi > (PIX_W + 1)'(GRAY_MAX)) ? PIX_W'(GRAY_MAX) : hi[PIX_W-1:0];
    endfunction

    function automatic logic [OUT_CNT_W-1:0] count_out(input count_t cnt);
        logic [OUT_CNT_W+COUNT_WIDTH-1:0] ext;
        ext = {{OUT_CNT_W{1'b0}}, cnt};
        return ext[OUT_CNT_W-1:0];
    endfunction

endpackage

[rtl/glbh_front.sv]
// ----------------------------------------------------------------------------
// glbh_front
// Input stage: register one pixel word, classify it into its bin.
// ----------------------------------------------------------------------------
module glbh_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [glbh_pkg::PIX_W-1:0] pixel_value,
    input  logic                      frame_end,
    output logic                      q_push,
    input  logic                      q_full,
    output glbh_pkg::entry_t          q_data
);
    import glbh_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    logic   load;

    assign q_push = valid_reg;
    assign q_data = entry_reg;
    // hold the word while the queue is full
    assign full   = valid_reg && q_full;
    assign load   = push && !full;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !q_full)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg.bin       <= pixel_to_bin(pixel_value);
            entry_reg.frame_end <= frame_end;
        end
    end

endmodule

[rtl/glbh_fifo.sv]
// ----------------------------------------------------------------------------
// glbh_fifo
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module glbh_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    output logic             q_full,
    input  glbh_pkg::entry_t wr_data,
    input  logic             rd_en,
    output logic             q_empty,
    output glbh_pkg::entry_t rd_data
);
    import glbh_pkg::*;

    entry_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   fill_reg;
    logic [FIFO_CW-1:0]   fill_next;
    logic                 do_wr;
    logic                 do_rd;

    assign q_full  = (fill_reg == FIFO_CW'(FIFO_DEPTH));
    assign q_empty = (fill_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/glbh_back.sv]
// ----------------------------------------------------------------------------
// glbh_back
// Bin counters, saturating update, and frame-end readout with clear.
// ----------------------------------------------------------------------------
module glbh_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  glbh_pkg::entry_t               q_data,
    output logic                           q_pop,
    input  logic                           pop,
    output logic                           empty,
    output logic [glbh_pkg::BIN_W-1:0]     bin_index,
    output logic [glbh_pkg::PIX_W-1:0]     range_start,
    output logic [glbh_pkg::PIX_W-1:0]     range_end,
    output logic [glbh_pkg::OUT_CNT_W-1:0] bin_count,
    output logic                           last_bin
);
    import glbh_pkg::*;

    typedef enum logic [1:0] {
        ST_COUNT = 2'b01,
        ST_DUMP  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    bin_t   idx_reg;
    bin_t   idx_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    bin_t   out_idx_reg;
    count_t out_cnt_reg;
    logic   out_last_reg;

    count_t cnt_reg [NUM_BINS];
    bin_t   rd_addr;
    count_t rd_val;
    logic   wr_en;
    count_t wr_val;
    logic   out_load;
    logic   dump_step;

    assign out_load  = !out_valid_reg || pop;
    assign dump_step = (state_reg == ST_DUMP) && out_load;
    assign rd_addr   = (state_reg == ST_DUMP) ? idx_reg : q_data.bin;
    assign rd_val    = cnt_reg[rd_addr];
    assign q_pop     = (state_reg == ST_COUNT) && !q_empty;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        wr_en          = 1'b0;
        wr_val         = rd_val;
        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_COUNT:
            begin
                if (q_pop)
                begin
                    // saturate instead of wrapping
                    wr_en  = (rd_val != '1);
                    wr_val = rd_val + 1'b1;
                    if (q_data.frame_end)
                    begin
                        state_next = ST_DUMP;
                        idx_next   = '0;
                    end
                end
            end
            ST_DUMP:
            begin
                if (dump_step)
                begin
                    // emit and clear this bin, advance
                    wr_en          = 1'b1;
                    wr_val         = '0;
                    out_valid_next = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                    if (idx_reg == LAST_BIN)
                    begin
                        state_next = ST_COUNT;
                    end
                end
            end
            default:
            begin
                state_next = ST_COUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COUNT;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BINS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                cnt_reg[rd_addr] <= wr_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dump_step)
        begin
            out_idx_reg  <= idx_reg;
            out_cnt_reg  <= rd_val;
            out_last_reg <= (idx_reg == LAST_BIN);
        end
    end

    assign empty       = !out_valid_reg;
    assign bin_index   = out_idx_reg;
    assign range_start = bin_start(out_idx_reg);
    assign range_end   = bin_end(out_idx_reg);
    assign bin_count   = count_out(out_cnt_reg);
    assign last_bin    = out_last_reg;

endmodule

[rtl/gray_level_binned_histogram_top.sv]
// ----------------------------------------------------------------------------
// gray_level_binned_histogram_top
// 26-bin gray-level histogram with saturating counters and frame-end readout.
// ----------------------------------------------------------------------------
// Push one 8-bit pixel word per cycle; it lands in bin pixel/10 (bin 25 holds
// 250..255), and each 16-bit counter sticks at its maximum. A word with
// frame_end set is counted first, then the 26 bins come out as 26 result
// words in index order, each with its gray-level range, count and a last_bin
// mark on bin 25, and every counter is cleared as it is read. Pixels stream
// at one word per cycle while full is low, each counted in the back end as it
// leaves the queue. A readout passes one bin per cycle through a single
// output register, and waits while pop stalls it; during a readout the
// input register and the four-entry queue absorb five more pixels before
// full rises.
// ----------------------------------------------------------------------------
module gray_level_binned_histogram_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [glbh_pkg::PIX_W-1:0]     pixel_value,
    input  logic                           frame_end,
    input  logic                           pop,
    output logic                           empty,
    output logic [glbh_pkg::BIN_W-1:0]     bin_index,
    output logic [glbh_pkg::PIX_W-1:0]     range_start,
    output logic [glbh_pkg::PIX_W-1:0]     range_end,
    output logic [glbh_pkg::OUT_CNT_W-1:0] bin_count,
    output logic                           last_bin
);
    import glbh_pkg::*;

    // front -> queue
    logic   f_push;
    logic   f_full;
    entry_t f_data;

    // queue -> back
    logic   b_pop;
    logic   b_empty;
    entry_t b_data;

    // Classify and register the incoming pixel word.
    glbh_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pixel_value (pixel_value),
        .frame_end   (frame_end),
        .q_push      (f_push),
        .q_full      (f_full),
        .q_data      (f_data)
    );

    // Decouple the input from the readout stall.
    glbh_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_push),
        .q_full  (f_full),
        .wr_data (f_data),
        .rd_en   (b_pop),
        .q_empty (b_empty),
        .rd_data (b_data)
    );

    // Count, then read out and clear at frame end.
    glbh_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (b_empty),
        .q_data      (b_data),
        .q_pop       (b_pop),
        .pop         (pop),
        .empty       (empty),
        .bin_index   (bin_index),
        .range_start (range_start),
        .range_end   (range_end),
        .bin_count   (bin_count),
        .last_bin    (last_bin)
    );

endmodule

[rtl/glbh_checker.sv]
// ----------------------------------------------------------------------------
// glbh_checker
// Port-level checks of the histogram readout sequence, bound to the top.
// ----------------------------------------------------------------------------
`include "gray_level_binned_histogram_top_assert.svh"

module glbh_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           pop,
    input logic                           empty,
    input logic [glbh_pkg::BIN_W-1:0]     bin_index,
    input logic [glbh_pkg::PIX_W-1:0]     range_start,
    input logic [glbh_pkg::PIX_W-1:0]     range_end,
    input logic                           last_bin
);
    import glbh_pkg::*;

    // last mark only on the final bin
    `GLBH_ASSERT_NOW(a_last_idx, !empty && last_bin, bin_index == LAST_BIN)
    // range start follows the index
    `GLBH_ASSERT_NOW(a_range, !empty, range_start == PIX_W'(PIX_W'(bin_index) * PIX_W'(BIN_SPAN)))
    // bins come out in order within a readout
    `GLBH_ASSERT_NEXT(a_order, !empty && pop && !last_bin, empty || bin_index == $past(bin_index) + 1'b1)
    // stalled result holds
    `GLBH_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(bin_index) && $stable(range_end))

endmodule

bind gray_level_binned_histogram_top glbh_checker u_glbh_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .pop         (pop),
    .empty       (empty),
    .bin_index   (bin_index),
    .range_start (range_start),
    .range_end   (range_end),
    .last_bin    (last_bin)
);
